// File: rtl/segmenting_packet_tx_queue_assert.svh
// Assertion macros shared by the segmenting packet transmit queue RTL.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef SEGMENTING_PACKET_TX_QUEUE_ASSERT_SVH
`define SEGMENTING_PACKET_TX_QUEUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/spq_pkg.sv
// Package for the segmenting packet transmit queue: constants, codes and types.
// No dependencies; imported by the top level, the front and the back.
package spq_pkg;

	localparam int SLOT_COUNT_DEF  = 4;
	localparam int SLOT_BYTES_DEF  = 256;
	localparam int CHUNK_CAP_DEF   = 64;
	localparam int MTU_OVERHEAD    = 3;
	localparam int SHORT_MTU_CHUNK = 20;
	localparam logic [6:0] MTU_RESET = 7'd23;
	localparam int JOB_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	typedef enum logic [1:0] {
		FN_BYTE       = 2'd0,
		FN_SEND       = 2'd1,
		FN_CONNECT    = 2'd2,
		FN_DISCONNECT = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_QUEUED    = 3'd0,
		ST_TOO_LONG  = 3'd1,
		ST_NO_LINK   = 3'd2,
		ST_DISCARDED = 3'd3,
		ST_BUSY      = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef enum logic {
		BK_IDLE   = 1'b0,
		BK_STREAM = 1'b1
	} back_state_t;

	// Control part of a job handed from the front to the back.
	typedef struct packed {
		logic    is_chunk;
		status_t status;
		logic    wants;
	} job_ctl_t;

	// One result item.
	typedef struct packed {
		logic       kind;
		logic [7:0] chunk_byte;
		logic       chunk_last;
		status_t    status_code;
		logic       wants_send;
	} res_t;

endpackage

// File: rtl/segmenting_packet_tx_queue.sv
// Segmenting packet transmit queue, top level: front, job queue, back, result queue.
// Path: an item's first result passes the job queue, the back's read register and the
// result queue; further chunk bytes follow at one per cycle while results drain.
// Throughput: one input item per cycle until the four-entry job queue fills; after a
// commit or a link event, input holds until every queued job has been carried out.
// Reset: arst_n clears pointers and state flags; the byte store and slot lengths are not cleared.
module segmenting_packet_tx_queue import spq_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int SLOT_BYTES = SLOT_BYTES_DEF,
	parameter int CHUNK_CAP  = CHUNK_CAP_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] func,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       link_accepts,
	output logic       empty,
	input  logic       pop,
	output logic       kind,
	output logic [7:0] chunk_byte,
	output logic       chunk_last,
	output logic [2:0] status_code,
	output logic       wants_send,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] cfg_data
);

	localparam int AW  = $clog2(SLOT_COUNT * SLOT_BYTES);
	localparam int CW  = $clog2(CHUNK_CAP + 1);
	localparam int OCW = $clog2(OUT_DEPTH + 1);
	localparam int JW  = $bits(job_ctl_t) + AW + CW;
	localparam int RW  = $bits(res_t);

	// front -> job queue
	logic          f_push;
	job_ctl_t      f_ctl;
	logic [AW-1:0] f_addr;
	logic [CW-1:0] f_n;
	logic          job_full, job_empty, job_pop;
	logic [JW-1:0] job_rdata;
	job_ctl_t      j_ctl;
	logic [AW-1:0] j_addr;
	logic [CW-1:0] j_n;

	// byte store write port
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;

	// back -> result queue
	logic           res_push, back_busy, outstanding;
	res_t           res_data, res_head;
	logic [RW-1:0]  res_rdata;
	logic [OCW-1:0] out_count;

	// After a commit or link event, hold input while any job may still read the store.
	assign outstanding = !job_empty || back_busy;

	spq_front #(
		.SLOT_COUNT(SLOT_COUNT),
		.SLOT_BYTES(SLOT_BYTES),
		.CHUNK_CAP (CHUNK_CAP)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.func        (func_t'(func)),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.link_accepts(link_accepts),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.job_full    (job_full),
		.outstanding (outstanding),
		.job_push    (f_push),
		.job_ctl     (f_ctl),
		.job_addr    (f_addr),
		.job_n       (f_n),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata)
	);

	// Job queue: decouples classification from chunk streaming.
	spq_fifo #(
		.WIDTH(JW),
		.DEPTH(JOB_DEPTH)
	) u_job_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_push),
		.wdata ({f_ctl, f_addr, f_n}),
		.full  (job_full),
		.pop   (job_pop),
		.rdata (job_rdata),
		.empty (job_empty),
		.count ()
	);

	assign {j_ctl, j_addr, j_n} = job_rdata;

	spq_back #(
		.SLOT_COUNT(SLOT_COUNT),
		.SLOT_BYTES(SLOT_BYTES),
		.CHUNK_CAP (CHUNK_CAP)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.job_empty(job_empty),
		.job_ctl  (j_ctl),
		.job_addr (j_addr),
		.job_n    (j_n),
		.job_pop  (job_pop),
		.out_count(out_count),
		.res_push (res_push),
		.res_data (res_data),
		.busy     (back_busy)
	);

	// Result queue: the back keeps streaming while the consumer stalls, until the queue has no room.
	spq_fifo #(
		.WIDTH(RW),
		.DEPTH(OUT_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_data),
		.full  (),
		.pop   (pop),
		.rdata (res_rdata),
		.empty (empty),
		.count (out_count)
	);

	assign res_head    = res_t'(res_rdata);
	assign kind        = res_head.kind;
	assign chunk_byte  = res_head.chunk_byte;
	assign chunk_last  = res_head.chunk_last;
	assign status_code = res_head.status_code;
	assign wants_send  = res_head.wants_send;

endmodule

// File: rtl/spq_fifo.sv
// Small synchronous FIFO in flip-flops, used for the job queue and result queue.
// Depends on nothing but its parameters.
module spq_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic [CNW-1:0]   count
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNW-1:0]   count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/spq_front.sv
// Front part: accepts input items, keeps the ring pointers and slot lengths,
// writes packet bytes and issues status or chunk jobs. Uses spq_pkg.
module spq_front import spq_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int SLOT_BYTES = SLOT_BYTES_DEF,
	parameter int CHUNK_CAP  = CHUNK_CAP_DEF,
	localparam int AW = $clog2(SLOT_COUNT * SLOT_BYTES),
	localparam int CW = $clog2(CHUNK_CAP + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  func_t         func,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	input  logic          link_accepts,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [6:0]    cfg_data,
	input  logic          job_full,
	input  logic          outstanding,
	output logic          job_push,
	output job_ctl_t      job_ctl,
	output logic [AW-1:0] job_addr,
	output logic [CW-1:0] job_n,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata
);

	localparam int SW   = $clog2(SLOT_COUNT);
	localparam int LENW = $clog2(SLOT_BYTES + 1);
	localparam int CNTW = $clog2(SLOT_BYTES + 2);
	localparam int NW   = (LENW > CW) ? LENW : CW;

	logic [6:0]      mtu_q, mtu_d;
	logic            link_up_q, link_up_d;
	logic            active_q, active_d;
	logic            drain_q, drain_d, drain_set;
	logic [SW-1:0]   write_slot_q, write_slot_d;
	logic [SW-1:0]   send_slot_q, send_slot_d;
	logic [LENW-1:0] offset_q, offset_d;
	logic [CNTW-1:0] cnt_q, cnt_d, cnt_inc;
	logic [LENW-1:0] len_q [SLOT_COUNT];
	logic            len_we;

	logic            accept, ring_empty;
	logic [LENW-1:0] len_cur, remaining;
	logic [6:0]      mtu_m3;
	logic [CW-1:0]   limit;
	logic [NW-1:0]   n_w;
	logic [NW:0]     off_sum;
	logic [SW-1:0]   wr_next, sd_next;

	function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
		return (s == SW'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
	endfunction

	assign cfg_ready = 1'b1;
	assign full      = job_full || (drain_q && outstanding);
	assign accept    = push && !full;

	// Byte store write port: only the first SLOT_BYTES bytes land.
	assign mem_we    = accept && (func == FN_BYTE) && (cnt_q < CNTW'(SLOT_BYTES));
	assign mem_waddr = AW'(write_slot_q) * AW'(SLOT_BYTES) + AW'(cnt_q);
	assign mem_wdata = data_byte;

	assign cnt_inc    = (cnt_q <= CNTW'(SLOT_BYTES)) ? cnt_q + 1'b1 : cnt_q;
	assign len_cur    = len_q[send_slot_q];
	assign remaining  = len_cur - offset_q;
	assign mtu_m3     = mtu_q - 7'(MTU_OVERHEAD);
	assign limit      = (mtu_q < 7'(MTU_OVERHEAD)) ? CW'(SHORT_MTU_CHUNK) :
		((mtu_m3 > 7'(CHUNK_CAP)) ? CW'(CHUNK_CAP) : CW'(mtu_m3));
	assign n_w        = (NW'(remaining) < NW'(limit)) ? NW'(remaining) : NW'(limit);
	assign off_sum    = (NW + 1)'(offset_q) + (NW + 1)'(n_w);
	assign ring_empty = (send_slot_q == write_slot_q);
	assign wr_next    = slot_next(write_slot_q);
	assign sd_next    = slot_next(send_slot_q);

	always_comb begin
		mtu_d        = cfg_valid ? cfg_data : mtu_q;
		link_up_d    = link_up_q;
		active_d     = active_q;
		write_slot_d = write_slot_q;
		send_slot_d  = send_slot_q;
		offset_d     = offset_q;
		cnt_d        = cnt_q;
		len_we       = 1'b0;
		drain_set    = 1'b0;
		job_push     = 1'b0;
		job_ctl      = '{is_chunk: 1'b0, status: ST_QUEUED, wants: 1'b0};
		job_addr     = '0;
		job_n        = '0;
		if (accept) begin
			case (func)
				FN_BYTE: begin
					if (last_byte) begin
						cnt_d    = '0;
						job_push = 1'b1;
						if (!link_up_q) begin
							job_ctl.status = ST_NO_LINK;
							job_ctl.wants  = active_q;
						end else if (cnt_inc > CNTW'(SLOT_BYTES)) begin
							job_ctl.status = ST_TOO_LONG;
							job_ctl.wants  = active_q;
						end else begin
							job_ctl.status = ST_QUEUED;
							if (wr_next == send_slot_q) begin
								// ring full: drop the oldest packet
								send_slot_d    = sd_next;
								offset_d       = '0;
								job_ctl.status = ST_DISCARDED;
							end
							len_we        = 1'b1;
							write_slot_d  = wr_next;
							active_d      = 1'b1;
							job_ctl.wants = 1'b1;
							drain_set     = 1'b1;
						end
					end else begin
						cnt_d = cnt_inc;
					end
				end
				FN_SEND: begin
					job_push = 1'b1;
					if (ring_empty) begin
						active_d       = 1'b0;
						offset_d       = '0;
						job_ctl.status = ST_EMPTY;
						job_ctl.wants  = 1'b0;
					end else if (!link_accepts || (n_w == '0)) begin
						job_ctl.status = ST_BUSY;
						job_ctl.wants  = 1'b1;
					end else begin
						job_ctl.is_chunk = 1'b1;
						job_addr = AW'(send_slot_q) * AW'(SLOT_BYTES) + AW'(offset_q);
						job_n    = CW'(n_w);
						job_ctl.wants = active_q;
						if (off_sum >= (NW + 1)'(len_cur)) begin
							// packet done: advance to the next slot
							send_slot_d = sd_next;
							offset_d    = '0;
							if (sd_next == write_slot_q) begin
								active_d      = 1'b0;
								job_ctl.wants = 1'b0;
							end
						end else begin
							offset_d = LENW'(off_sum);
						end
					end
				end
				FN_CONNECT: begin
					link_up_d    = 1'b1;
					active_d     = 1'b0;
					write_slot_d = '0;
					send_slot_d  = '0;
					offset_d     = '0;
					cnt_d        = '0;
					drain_set    = 1'b1;
				end
				default: begin
					link_up_d    = 1'b0;
					active_d     = 1'b0;
					write_slot_d = '0;
					send_slot_d  = '0;
					offset_d     = '0;
					cnt_d        = '0;
					drain_set    = 1'b1;
				end
			endcase
		end
		drain_d = drain_set || (drain_q && outstanding);
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_q[write_slot_q] <= LENW'(cnt_inc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mtu_q        <= MTU_RESET;
			link_up_q    <= 1'b0;
			active_q     <= 1'b0;
			drain_q      <= 1'b0;
			write_slot_q <= '0;
			send_slot_q  <= '0;
			offset_q     <= '0;
			cnt_q        <= '0;
		end else begin
			mtu_q        <= mtu_d;
			link_up_q    <= link_up_d;
			active_q     <= active_d;
			drain_q      <= drain_d;
			write_slot_q <= write_slot_d;
			send_slot_q  <= send_slot_d;
			offset_q     <= offset_d;
			cnt_q        <= cnt_d;
		end
	end

endmodule

// File: rtl/spq_back.sv
// Back part: holds the packet byte store, takes jobs and streams chunk bytes
// or status reports into the result queue. Uses spq_pkg and the assertion macros.
`include "segmenting_packet_tx_queue_assert.svh"
module spq_back import spq_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int SLOT_BYTES = SLOT_BYTES_DEF,
	parameter int CHUNK_CAP  = CHUNK_CAP_DEF,
	localparam int AW  = $clog2(SLOT_COUNT * SLOT_BYTES),
	localparam int CW  = $clog2(CHUNK_CAP + 1),
	localparam int OCW = $clog2(OUT_DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mem_we,
	input  logic [AW-1:0]  mem_waddr,
	input  logic [7:0]     mem_wdata,
	input  logic           job_empty,
	input  job_ctl_t       job_ctl,
	input  logic [AW-1:0]  job_addr,
	input  logic [CW-1:0]  job_n,
	output logic           job_pop,
	input  logic [OCW-1:0] out_count,
	output logic           res_push,
	output res_t           res_data,
	output logic           busy
);

	logic [7:0]    store_q [SLOT_COUNT * SLOT_BYTES];
	back_state_t   state_q, state_d;
	logic [AW-1:0] addr_q;
	logic [CW-1:0] left_q;
	logic          wants_q;
	logic          credit, issue;
	logic [AW-1:0] rd_addr;
	logic          kind_n, last_n, wants_n;
	status_t       status_n;

	logic          valid_s1, kind_s1, last_s1, wants_s1;
	status_t       status_s1;
	logic [7:0]    rdata_s1;

	// room in the result queue, counting the read already in flight
	assign credit = ((OCW + 1)'(out_count) + (OCW + 1)'(valid_s1)) < (OCW + 1)'(OUT_DEPTH);
	assign busy   = (state_q == BK_STREAM);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!job_empty && credit && job_ctl.is_chunk && (job_n != CW'(1))) begin
					state_d = BK_STREAM;
				end
			end
			BK_STREAM: begin
				if (credit && (left_q == CW'(1))) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_pop  = 1'b0;
		issue    = 1'b0;
		rd_addr  = addr_q;
		kind_n   = 1'b1;
		last_n   = 1'b0;
		status_n = ST_QUEUED;
		wants_n  = wants_q;
		case (state_q)
			BK_IDLE: begin
				job_pop  = !job_empty && credit;
				issue    = job_pop;
				rd_addr  = job_addr;
				kind_n   = job_ctl.is_chunk;
				last_n   = job_ctl.is_chunk && (job_n == CW'(1));
				status_n = job_ctl.is_chunk ? ST_QUEUED : job_ctl.status;
				wants_n  = job_ctl.wants;
			end
			BK_STREAM: begin
				issue  = credit;
				last_n = (left_q == CW'(1));
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_waddr] <= mem_wdata;
		end
		if (issue) begin
			rdata_s1  <= store_q[rd_addr];
			kind_s1   <= kind_n;
			last_s1   <= last_n;
			status_s1 <= status_n;
			wants_s1  <= wants_n;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && job_pop) begin
			addr_q  <= job_addr + 1'b1;
			left_q  <= job_n - 1'b1;
			wants_q <= job_ctl.wants;
		end else if (state_q == BK_STREAM && issue) begin
			addr_q <= addr_q + 1'b1;
			left_q <= left_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
		end
	end

	assign res_push = valid_s1;
	always_comb begin
		res_data.kind        = kind_s1;
		res_data.chunk_byte  = kind_s1 ? rdata_s1 : 8'h00;
		res_data.chunk_last  = last_s1;
		res_data.status_code = status_s1;
		res_data.wants_send  = wants_s1;
	end

	`SPQ_ASSERT_IMP(a_left_nz, clk, arst_n, state_q == BK_STREAM, left_q != '0, "stream count zero")
	`SPQ_ASSERT_NXT(a_end, clk, arst_n, busy && issue && left_q == CW'(1), !busy, "stream overran")
	`SPQ_ASSERT_IMP(a_room, clk, arst_n, res_push, out_count < OCW'(OUT_DEPTH), "result overflow")
	`SPQ_ASSERT_IMP(a_job_n, clk, arst_n, job_pop && job_ctl.is_chunk, job_n != '0, "empty chunk")

endmodule
